// ===== sv/ray_voxel_traversal_defines.svh =====
// Assertion macros shared by the checker of the voxel traversal block.
// Expects clk and rst_n in the scope of every use.
`ifndef RAY_VOXEL_TRAVERSAL_DEFINES_SVH
`define RAY_VOXEL_TRAVERSAL_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvt assertion failed");

// Next-cycle implication, disabled during reset
`define RVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvt assertion failed");

`endif

// ===== sv/rvt_pkg.sv =====
// Shared types and constants of the voxel traversal block.
// No dependencies.
`timescale 1ns / 1ps

package rvt_pkg;

  localparam int COORD_W = 32;
  localparam int TAG_W   = 24;
  localparam int VOX_W   = 12;
  localparam int IN_W    = 6 * COORD_W + TAG_W;
  localparam int OUT_W   = 64;
  localparam int ADDR_W  = 4;

  // Register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_BOX_MIN_X = 2'd0;
  localparam logic [1:0] REG_BOX_MIN_Y = 2'd1;
  localparam logic [1:0] REG_BOX_MIN_Z = 2'd2;
  localparam logic [1:0] REG_INV_WIDTH = 2'd3;
  localparam logic [31:0] INV_WIDTH_RESET = 32'd262144;

  // Sequencer step counts
  localparam logic [3:0] CONV_LAST  = 4'd5;  // six point conversions
  localparam logic [3:0] SQ_STEPS   = 4'd3;  // three squares for the length
  localparam logic [3:0] SETUP_LAST = 4'd8;  // plus six cross products

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Cross products P[j] = num[PAIR_A[j]] * dmag[PAIR_B[j]]
  localparam logic [1:0] PAIR_A [6] = '{AXIS_X, AXIS_Y, AXIS_X, AXIS_Z, AXIS_Y, AXIS_Z};
  localparam logic [1:0] PAIR_B [6] = '{AXIS_Y, AXIS_X, AXIS_Z, AXIS_X, AXIS_Z, AXIS_Y};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_SETUP,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       prep;
    logic       setup;
    logic       step;
    logic [3:0] k;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic last_now;
  } sts_t;

endpackage

// ===== sv/ray_voxel_traversal.sv =====
// Top level of the 3-D voxel traversal: APB register file, sequencer, datapath.
// Depends on rvt_pkg, rvt_ctrl and rvt_datapath.
//
//   channel  | dir | handshake        | payload
//   in_      | in  | tvalid/tready    | tdata: start_x,y,z, end_x,y,z, ray_id
//   out_     | out | tvalid/tready    | tdata: voxel_x,y,z, ray_tag; tlast; tuser
//   cfg_     | in  | psel/penable     | box_min_x,y,z, inv_voxel_width
//
// A ray passes through accept, point conversion, prepare and setup on the one
// shared multiplier, then the walk emits one voxel per cycle while the output
// is not stalled (up to MAX_STEPS).
// A walk step stalls while the output register holds an untaken request.
// Reset returns the sequencer to idle and drops any pending output request.
`timescale 1ns / 1ps

module ray_voxel_traversal #(
  parameter int MAX_STEPS  = 64,
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x[31:0], start_y, start_z, end_x, end_y, end_z, ray_id[215:192]
  input  logic [rvt_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // voxel_x[11:0], voxel_y[23:12], voxel_z[35:24], ray_tag[59:36], zero pad
  output logic [rvt_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tlast,
  // truncated
  output logic [0:0]                    out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rvt_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [2:0][31:0] box_r;
  logic [31:0]      inv_r;
  logic [1:0]       reg_idx;
  rvt_pkg::cmd_t    cmd;
  rvt_pkg::sts_t    sts;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
      inv_r <= rvt_pkg::INV_WIDTH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx)
        rvt_pkg::REG_BOX_MIN_X: box_r[0] <= cfg_pwdata;
        rvt_pkg::REG_BOX_MIN_Y: box_r[1] <= cfg_pwdata;
        rvt_pkg::REG_BOX_MIN_Z: box_r[2] <= cfg_pwdata;
        default:                inv_r    <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rvt_pkg::REG_BOX_MIN_X: cfg_prdata = box_r[0];
      rvt_pkg::REG_BOX_MIN_Y: cfg_prdata = box_r[1];
      rvt_pkg::REG_BOX_MIN_Z: cfg_prdata = box_r[2];
      default:                cfg_prdata = inv_r;
    endcase
  end

  rvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rvt_datapath #(
    .MAX_STEPS  (MAX_STEPS),
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .box_min    (box_r),
    .inv_width  (inv_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser[0])
  );

endmodule

// ===== sv/rvt_ctrl.sv =====
// Sequencer of the voxel traversal: load, convert, prepare, set up, walk.
// Depends on rvt_pkg.
`timescale 1ns / 1ps

module rvt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          out_tready,
  input  rvt_pkg::sts_t sts,
  output rvt_pkg::cmd_t cmd
);

  rvt_pkg::state_t state_r, state_nxt;
  logic [3:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.k     = cnt_r;
    case (state_r)
      rvt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = rvt_pkg::ST_CONV;
        end
      end
      rvt_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == rvt_pkg::CONV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = rvt_pkg::ST_PREP;
        end
      end
      rvt_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = rvt_pkg::ST_SETUP;
      end
      rvt_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == rvt_pkg::SETUP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = rvt_pkg::ST_WALK;
        end
      end
      rvt_pkg::ST_WALK: begin
        // advance only when the output register is free or being drained
        cmd.step = !sts.out_valid || out_tready;
        if (cmd.step && sts.last_now) begin
          state_nxt = rvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rvt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rvt_datapath.sv =====
// Datapath of the voxel traversal: shared multiplier, grid conversion,
// cross-product boundary compare and the output register. Depends on rvt_pkg.
`timescale 1ns / 1ps

module rvt_datapath #(
  parameter int MAX_STEPS  = 64,
  parameter int INDEX_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rvt_pkg::cmd_t                cmd,
  output rvt_pkg::sts_t                sts,
  input  logic [rvt_pkg::IN_W-1:0]     in_tdata,
  input  logic [2:0][31:0]             box_min,
  input  logic [31:0]                  inv_width,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [rvt_pkg::OUT_W-1:0]    out_tdata,
  output logic                         out_tlast,
  output logic                         out_tuser
);

  localparam int GW  = INDEX_BITS + FRAC_BITS;      // signed grid coordinate
  localparam int DW  = GW + 1;                      // signed grid direction
  localparam int NW  = GW + 2;                      // signed boundary numerator
  localparam int CVW = INDEX_BITS + 8;              // voxel index with walk margin
  localparam int PW  = 2 * GW + 10;                 // cross product
  localparam int LW  = 2 * CVW + 3;                 // squared index length
  localparam int MA  = (GW + 1 > 33) ? GW + 1 : 33;
  localparam int MB  = (GW > 32) ? GW : 32;
  localparam int SW  = $clog2(MAX_STEPS + 1);

  // captured request
  logic [31:0]             coord_r [6];
  logic [rvt_pkg::TAG_W-1:0] tag_r;

  // converted points: slots 0..2 start, 3..5 end
  logic signed [GW-1:0]    grid_r [6];
  logic signed [CVW-1:0]   vidx_r [6];

  // per-axis walk state
  logic                    pos_r [3];
  logic                    neg_r [3];
  logic [GW-1:0]           dmag_r [3];
  logic signed [NW-1:0]    num_r [3];
  logic [CVW-1:0]          emag_r [3];
  logic signed [CVW-1:0]   first_r [3];
  logic signed [CVW-1:0]   final_r [3];
  logic signed [CVW-1:0]   cur_r [3];
  logic signed [PW-1:0]    prod_r [6];
  logic [LW-1:0]           lensq_r;
  logic [LW-1:0]           dist_r;
  logic [SW-1:0]           cnt_r;

  logic                    out_valid_r;
  logic [rvt_pkg::OUT_W-1:0] out_data_r;
  logic                    out_last_r;
  logic                    out_trunc_r;

  // ---------------- shared multiplier ----------------
  logic [2:0]           ks;
  logic [1:0]           kaxis;
  logic [2:0]           pj;
  logic [1:0]           pa, pb;
  logic signed [32:0]   diff;
  logic                 cneg;
  logic [32:0]          cmag;
  logic [NW-1:0]        nmag;
  logic                 nneg;
  logic [MA-1:0]        ma;
  logic [MB-1:0]        mb;
  logic [MA+MB-1:0]     prod;

  assign ks = cmd.k[2:0];

  always_comb begin
    case (ks)
      3'd0, 3'd3: kaxis = rvt_pkg::AXIS_X;
      3'd1, 3'd4: kaxis = rvt_pkg::AXIS_Y;
      default:    kaxis = rvt_pkg::AXIS_Z;
    endcase
  end

  assign diff = $signed({coord_r[ks][31], coord_r[ks]}) -
                $signed({box_min[kaxis][31], box_min[kaxis]});
  assign cneg = diff[32];
  assign cmag = cneg ? 33'(-diff) : 33'(diff);

  assign pj   = (cmd.k >= rvt_pkg::SQ_STEPS) ? 3'(cmd.k - rvt_pkg::SQ_STEPS) : 3'd0;
  assign pa   = rvt_pkg::PAIR_A[pj];
  assign pb   = rvt_pkg::PAIR_B[pj];
  assign nneg = num_r[pa] < 0;
  assign nmag = nneg ? NW'(-num_r[pa]) : NW'(num_r[pa]);

  always_comb begin
    if (cmd.conv) begin
      ma = MA'(cmag);
      mb = MB'(inv_width);
    end else if (cmd.k < rvt_pkg::SQ_STEPS) begin
      ma = MA'(emag_r[kaxis]);
      mb = MB'(emag_r[kaxis]);
    end else begin
      ma = MA'(nmag);
      mb = MB'(dmag_r[pb]);
    end
  end

  assign prod = ma * mb;

  // ---------------- conversion result ----------------
  logic                 sat;
  logic [GW-2:0]        gmag;
  logic [INDEX_BITS-2:0] imag;

  assign sat  = |prod[MA+MB-1:31+INDEX_BITS];
  assign gmag = sat ? '1 : prod[30+INDEX_BITS:32-FRAC_BITS];
  assign imag = gmag[GW-2:FRAC_BITS];

  // ---------------- walk step ----------------
  logic              match, done, last_now;
  logic              lt01, lt02, lt10, lt12;
  logic [1:0]        pick;
  logic signed [CVW:0] epk;
  logic signed [CVW+2:0] term;
  logic [GW+FRAC_BITS-1:0] add0, add1, add2;

  assign match = (cur_r[0] == final_r[0]) && (cur_r[1] == final_r[1]) &&
                 (cur_r[2] == final_r[2]);
  assign done     = match || (dist_r > lensq_r);
  assign last_now = done || (cnt_r == SW'(MAX_STEPS - 1));

  assign lt01 = prod_r[0] < prod_r[1];
  assign lt10 = prod_r[1] < prod_r[0];
  assign lt02 = prod_r[2] < prod_r[3];
  assign lt12 = prod_r[4] < prod_r[5];

  always_comb begin
    // ties go to z if it moves, else to y; a flat axis wins only when all three are flat
    if (dmag_r[0] != '0 && (dmag_r[1] == '0 || lt01) && (dmag_r[2] == '0 || lt02))
      pick = rvt_pkg::AXIS_X;
    else if (dmag_r[1] != '0 && (dmag_r[0] == '0 || lt10) && (dmag_r[2] == '0 || lt12))
      pick = rvt_pkg::AXIS_Y;
    else if (dmag_r[2] != '0)
      pick = rvt_pkg::AXIS_Z;
    else
      pick = (dmag_r[1] != '0) ? rvt_pkg::AXIS_Y : rvt_pkg::AXIS_X;
  end

  // squared distance moves by 2*s*e + 1 for one unit step
  assign epk  = (CVW+1)'(cur_r[pick]) - (CVW+1)'(first_r[pick]);
  assign term = pos_r[pick] ? ((CVW+3)'(epk) <<< 1) + (CVW+3)'(1)
                            : (CVW+3)'(1) - ((CVW+3)'(epk) <<< 1);

  assign add0 = (GW+FRAC_BITS)'(dmag_r[0]) << FRAC_BITS;
  assign add1 = (GW+FRAC_BITS)'(dmag_r[1]) << FRAC_BITS;
  assign add2 = (GW+FRAC_BITS)'(dmag_r[2]) << FRAC_BITS;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 6; i++) begin
        coord_r[i] <= in_tdata[i*32 +: 32];
      end
      tag_r <= in_tdata[6*32 +: rvt_pkg::TAG_W];
    end

    if (cmd.conv) begin
      grid_r[ks] <= cneg ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
      vidx_r[ks] <= cneg ? -$signed(CVW'(imag)) : $signed(CVW'(imag));
    end

    if (cmd.prep) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [DW-1:0] dir;
        logic signed [NW-1:0] bnd;
        logic signed [CVW-1:0] ed;
        dir = DW'(grid_r[a+3]) - DW'(grid_r[a]);
        bnd = (NW'(vidx_r[a]) <<< FRAC_BITS) +
              ((dir > 0) ? (NW'(1) <<< FRAC_BITS) : NW'(0));
        ed  = vidx_r[a+3] - vidx_r[a];
        pos_r[a]   <= dir > 0;
        neg_r[a]   <= dir < 0;
        dmag_r[a]  <= (dir < 0) ? GW'(-dir) : GW'(dir);
        num_r[a]   <= (dir > 0) ? bnd - NW'(grid_r[a]) :
                      (dir < 0) ? NW'(grid_r[a]) - bnd : NW'(0);
        emag_r[a]  <= (ed < 0) ? CVW'(-ed) : CVW'(ed);
        first_r[a] <= vidx_r[a];
        final_r[a] <= vidx_r[a+3];
        cur_r[a]   <= vidx_r[a];
      end
      dist_r <= '0;
      cnt_r  <= '0;
    end

    if (cmd.setup) begin
      if (cmd.k == '0)
        lensq_r <= LW'(prod);
      else if (cmd.k < rvt_pkg::SQ_STEPS)
        lensq_r <= lensq_r + LW'(prod);
      else
        prod_r[pj] <= nneg ? -$signed(PW'(prod)) : $signed(PW'(prod));
    end

    if (cmd.step) begin
      cnt_r  <= cnt_r + SW'(1);
      dist_r <= LW'($signed(LW'(dist_r)) + $signed(LW'(term)));
      cur_r[pick] <= pos_r[pick] ? cur_r[pick] + CVW'(1) :
                     neg_r[pick] ? cur_r[pick] - CVW'(1) : cur_r[pick];
      case (pick)
        rvt_pkg::AXIS_X: begin
          prod_r[0] <= prod_r[0] + PW'(add1);
          prod_r[2] <= prod_r[2] + PW'(add2);
        end
        rvt_pkg::AXIS_Y: begin
          prod_r[1] <= prod_r[1] + PW'(add0);
          prod_r[4] <= prod_r[4] + PW'(add2);
        end
        default: begin
          prod_r[3] <= prod_r[3] + PW'(add0);
          prod_r[5] <= prod_r[5] + PW'(add1);
        end
      endcase
      out_data_r  <= {4'd0, tag_r, cur_r[2][rvt_pkg::VOX_W-1:0],
                      cur_r[1][rvt_pkg::VOX_W-1:0], cur_r[0][rvt_pkg::VOX_W-1:0]};
      out_last_r  <= last_now;
      out_trunc_r <= last_now && !done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_valid = out_valid_r;
  assign sts.last_now  = last_now;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tlast     = out_last_r;
  assign out_tuser     = out_trunc_r;

endmodule

// ===== sv/rvt_checker.sv =====
// Port-level checks of the voxel traversal, bound to the top level.
// Depends on rvt_pkg and ray_voxel_traversal_defines.svh.
`timescale 1ns / 1ps
`include "ray_voxel_traversal_defines.svh"

module rvt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [rvt_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast,
  input logic [0:0]                out_tuser
);

  `RVT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RVT_ASSERT_NOW(a_trunc_on_last, out_tvalid && out_tuser[0], out_tlast)
  `RVT_ASSERT_NEXT(a_one_ray_at_a_time, in_tvalid && in_tready, !in_tready)
  `RVT_ASSERT_NEXT(a_walk_continues, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tdata[59:36] == $past(out_tdata[59:36]))

endmodule

bind ray_voxel_traversal rvt_checker u_rvt_checker (.*);
